FILE: design/firs_pkg.sv
`timescale 1ns / 1ps
// shared constants for the saturating fir filter
// no dependencies

package firs_pkg;

	// filter length and derived storage sizes
	localparam int TAPS  = 81;
	localparam int DEPTH = TAPS - 1;
	localparam int CI_W  = $clog2(TAPS);
	localparam int DI_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// data widths
	localparam int SAMPLE_W = 16;
	localparam int PROD_W   = 2 * SAMPLE_W;
	localparam int ACC_W    = PROD_W + 1 + $clog2(TAPS);
	localparam int FRAC_W   = 15;

	// q1.15 limits
	localparam int Q_MAX = 32767;
	localparam int Q_MIN = -32768;

	// command codes carried in tuser
	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_FILTER = 1'b1;

endpackage

FILE: design/fir_filter_saturating.sv
`timescale 1ns / 1ps
// top level of the saturating direct-form fir filter
// depends on firs_pkg for sizes, limits and command codes

// Direct-form FIR filter over Q1.15 samples with a coefficient store loaded by
// stream transactions. A transaction with tuser = 0 writes one coefficient (an
// index at or beyond the tap count is dropped) and produces no output. A
// transaction with tuser = 1 filters one sample: after the accepting cycle it
// steps through every tap in turn (81 taps) on a single multiply-accumulate
// unit, fed by one read port on each of the coefficient and delay-line
// memories, then drains the read and product pipeline stages, and a final
// state (FIN) writes the result and stores the sample in the delay line.
// The delay line is a circular buffer; a fill count makes unwritten entries
// read as zero and per-entry valid flags do the same for coefficients, so no
// clearing pass follows reset. The output register holds a result until it is
// taken while the next transaction is accepted and processed; a finished sample
// waits in its last cycle only if the previous result is still pending. The
// result is rounded to nearest (ties up) and saturated to [-32768, 32767].

module fir_filter_saturating (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // coef_index[7:0], coef_value[23:8], sample[39:24]
	input  logic        s_tuser,  // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // filtered[15:0]
);

	localparam int ACC_W = firs_pkg::ACC_W;
	localparam int CI_W  = firs_pkg::CI_W;
	localparam int DI_W  = firs_pkg::DI_W;
	localparam int SW    = firs_pkg::SAMPLE_W;

	localparam logic signed [ACC_W-1:0] RND    = ACC_W'(1 << (firs_pkg::FRAC_W - 1));
	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(firs_pkg::Q_MAX);
	localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(firs_pkg::Q_MIN);
	localparam logic [CI_W-1:0] K_LAST = CI_W'(firs_pkg::TAPS - 1);
	localparam logic [DI_W-1:0] D_LAST = DI_W'(firs_pkg::DEPTH - 1);
	localparam logic [CI_W-1:0] F_MAX  = CI_W'(firs_pkg::DEPTH);

	typedef enum logic [1:0] {
		IDLE,
		RUN,
		DRAIN,
		FIN
	} state_t;

	state_t state_q;

	// storage
	logic signed [SW-1:0] coef_mem [firs_pkg::TAPS];
	logic signed [SW-1:0] dly_mem  [firs_pkg::DEPTH];
	logic [firs_pkg::TAPS-1:0] coef_vld_q;

	// control registers
	logic [CI_W-1:0]      k_q;
	logic [DI_W-1:0]      rd_q;
	logic [DI_W-1:0]      wptr_q;
	logic [CI_W-1:0]      fill_q;
	logic signed [SW-1:0] x_q;
	logic signed [ACC_W-1:0] acc_q;

	// pipeline registers
	logic                 vld_s1, last_s1, tap0_s1, cv_s1, dv_s1;
	logic signed [SW-1:0] coef_s1, dly_s1;
	logic                 vld_s2, last_s2;
	logic signed [firs_pkg::PROD_W-1:0] prod_s2;

	// output register
	logic        m_tvalid_q;
	logic [15:0] m_tdata_q;

	// input field unpacking
	logic [7:0]           in_idx;
	logic signed [SW-1:0] in_coef;
	logic signed [SW-1:0] in_sample;
	logic                 s_acc;
	logic                 coef_we;
	logic [CI_W-1:0]      coef_waddr;
	logic                 out_free;
	logic                 dly_we;
	logic [DI_W-1:0]      rd_start;
	logic signed [SW-1:0] op_c, op_d;
	logic signed [ACC_W-1:0] y_full;
	logic [15:0]          y_sat;

	assign in_idx    = s_tdata[7:0];
	assign in_coef   = $signed(s_tdata[23:8]);
	assign in_sample = $signed(s_tdata[39:24]);

	assign s_tready = (state_q == IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign coef_we  = s_acc && (s_tuser == firs_pkg::CMD_LOAD)
		&& ({1'b0, in_idx} < 9'(firs_pkg::TAPS));
	assign coef_waddr = in_idx[CI_W-1:0];
	assign out_free = !m_tvalid_q || m_tready;
	assign dly_we   = (state_q == FIN) && out_free;
	assign rd_start = (wptr_q == '0) ? D_LAST : wptr_q - DI_W'(1);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// coefficient memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (coef_we) begin
			coef_mem[coef_waddr] <= in_coef;
		end
		coef_s1 <= coef_mem[k_q];
	end

	// delay-line memory, written once per sample after all taps are read
	always_ff @(posedge clk) begin
		if (dly_we) begin
			dly_mem[wptr_q] <= x_q;
		end
		dly_s1 <= dly_mem[rd_q];
	end

	// coefficient valid flags, unwritten entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_vld_q <= '0;
		end else if (coef_we) begin
			coef_vld_q[coef_waddr] <= 1'b1;
		end
	end

	// operand selection and multiply
	always_comb begin
		op_c = cv_s1 ? coef_s1 : '0;
		if (tap0_s1) begin
			op_d = x_q;
		end else begin
			op_d = dv_s1 ? dly_s1 : '0;
		end
	end

	// tap pipeline: read stage, product stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			vld_s2  <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			vld_s1  <= (state_q == RUN);
			last_s1 <= (state_q == RUN) && (k_q == K_LAST);
			vld_s2  <= vld_s1;
			last_s2 <= last_s1;
		end
	end

	always_ff @(posedge clk) begin
		tap0_s1 <= (k_q == '0);
		cv_s1   <= coef_vld_q[k_q];
		dv_s1   <= (k_q <= fill_q);
		prod_s2 <= op_c * op_d;
	end

	// rounding and saturation of the final sum
	always_comb begin
		y_full = (acc_q + RND) >>> firs_pkg::FRAC_W;
		if (y_full > SAT_HI) begin
			y_sat = 16'(firs_pkg::Q_MAX);
		end else if (y_full < SAT_LO) begin
			y_sat = 16'(firs_pkg::Q_MIN);
		end else begin
			y_sat = y_full[15:0];
		end
	end

	// sequencer, accumulator and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= IDLE;
			k_q        <= '0;
			rd_q       <= '0;
			wptr_q     <= '0;
			fill_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// output valid: set when a result is stored, cleared when taken
			if (dly_we) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (s_acc && (s_tuser == firs_pkg::CMD_FILTER)) begin
						state_q <= RUN;
						k_q     <= '0;
						rd_q    <= rd_start;
					end
				end
				RUN: begin
					// tap zero takes the new sample, so the delay pointer moves from tap one on
					if (k_q != '0) begin
						rd_q <= (rd_q == '0) ? D_LAST : rd_q - DI_W'(1);
					end
					if (k_q == K_LAST) begin
						state_q <= DRAIN;
					end else begin
						k_q <= k_q + CI_W'(1);
					end
				end
				DRAIN: begin
					if (last_s2) begin
						state_q <= FIN;
					end
				end
				FIN: begin
					if (out_free) begin
						state_q    <= IDLE;
						wptr_q     <= (wptr_q == D_LAST) ? '0 : wptr_q + DI_W'(1);
						if (fill_q != F_MAX) begin
							fill_q <= fill_q + CI_W'(1);
						end
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_acc && (s_tuser == firs_pkg::CMD_FILTER)) begin
			x_q   <= in_sample;
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
		if (dly_we) begin
			m_tdata_q <= y_sat;
		end
	end

`ifndef SYNTHESIS
	// fill count never passes the delay-line depth
	assert property (@(posedge clk) disable iff (!arst_n) fill_q <= F_MAX)
		else $error("delay-line fill count out of range");

	// no new transaction is taken while a sample is in flight
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != IDLE) |-> !s_tready)
		else $error("input ready while busy");

	// a result never appears in the cycle after a sample is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser == firs_pkg::CMD_FILTER)) |=> !$rose(m_tvalid))
		else $error("result too early after sample");

	// the delay line is only advanced when the result can be stored
	assert property (@(posedge clk) disable iff (!arst_n)
		dly_we |-> (!m_tvalid || m_tready))
		else $error("result overwritten while pending");
`endif

endmodule

FILE: sim/fir_filter_saturating_checker.sv
`timescale 1ns / 1ps
// checker for the saturating fir filter: watches both stream channels,
// predicts each filtered sample and compares it; depends on firs_pkg

module fir_filter_saturating_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,  // coef_index[7:0], coef_value[23:8], sample[39:24]
	input  logic        s_tuser,  // cmd
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,  // filtered[15:0]
	output int          errors,
	output int          pending
);

	// predictor state: coefficient bank and sample history, newest first
	logic signed [firs_pkg::SAMPLE_W-1:0] coef_bank [firs_pkg::TAPS] = '{default: '0};
	logic signed [firs_pkg::SAMPLE_W-1:0] history [firs_pkg::DEPTH] = '{default: '0};
	logic [firs_pkg::SAMPLE_W-1:0] expected_outputs [$];
	int fail_count = 0;
	int queued = 0;

	assign errors  = fail_count;
	assign pending = queued;

	// exact tap sum, round half up, clamp to q1.15, then shift the sample in
	function automatic logic [firs_pkg::SAMPLE_W-1:0] next_filtered(
			input logic signed [firs_pkg::SAMPLE_W-1:0] x);
		longint acc;
		longint y;
		acc = longint'(coef_bank[0]) * longint'(x);
		for (int k = 1; k < firs_pkg::TAPS; k++)
			acc += longint'(coef_bank[k]) * longint'(history[k-1]);
		y = (acc + 64'sd16384) >>> firs_pkg::FRAC_W;
		if (y > firs_pkg::Q_MAX) y = firs_pkg::Q_MAX;
		if (y < firs_pkg::Q_MIN) y = firs_pkg::Q_MIN;
		for (int k = firs_pkg::DEPTH - 1; k > 0; k--) history[k] = history[k-1];
		history[0] = x;
		return y[firs_pkg::SAMPLE_W-1:0];
	endfunction

	// compare output transactions, then fold in the input transaction
	always @(posedge clk) begin : watch
		logic [firs_pkg::SAMPLE_W-1:0] want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_outputs.size() == 0) begin
					$display("%0t ns: unexpected output, expected none, actual %h",
						$time, m_tdata);
					fail_count++;
				end else begin
					want = expected_outputs.pop_front();
					if (m_tdata !== want) begin
						$display("%0t ns: filtered mismatch, expected %h, actual %h",
							$time, want, m_tdata);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser == firs_pkg::CMD_LOAD) begin
					// indexes past the last tap are dropped
					if (s_tdata[7:0] < firs_pkg::TAPS)
						coef_bank[s_tdata[firs_pkg::CI_W-1:0]] = s_tdata[23:8];
				end else begin
					expected_outputs.push_back(next_filtered(s_tdata[39:24]));
				end
			end
			queued = expected_outputs.size();
		end
	end

endmodule

FILE: sim/fir_filter_saturating_tb.sv
`timescale 1ns / 1ps
// testbench top for the saturating fir filter: clock, reset, stimulus,
// output backpressure and verdict; depends on firs_pkg and the checker

module fir_filter_saturating_tb;

	localparam int RANDOM_ITEMS = 1580;
	localparam int IDLE_LIMIT   = 5000;
	localparam int HOLDOFF_AT   = 2500;
	localparam int HOLDOFF_LEN  = 700;
	localparam int SETTLE       = 200;

	typedef enum int {RX_FREE, RX_COIN, RX_MOSTLY, RX_CADENCE} rx_mode_t;
	typedef enum int {COEF_FULL, COEF_SMALL, COEF_EXTREME} coef_style_t;
	typedef enum int {SMP_FULL, SMP_EXTREME, SMP_SMALL, SMP_ZERO} smp_style_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;   // coef_index[7:0], coef_value[23:8], sample[39:24]
	logic        s_tuser = 1'b0; // cmd
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // filtered[15:0]
	int          errors;
	int          pending;
	int          burst_left = 0;

	always #6 clk = ~clk;

	fir_filter_saturating dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	fir_filter_saturating_checker checker_i (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.errors   (errors),
		.pending  (pending)
	);

	// offer one transaction and wait for it to be taken; bursts may end in a gap
	task automatic send_item(input logic cmd, input logic [7:0] idx,
			input logic [15:0] cval, input logic [15:0] smp);
		int gap;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {smp, cval, idx};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 8);
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
			if (gap > 0) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
	endtask

	// stop offering until every predicted output has come out
	task automatic drain_outputs();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	// output backpressure: changing patterns plus one long hold-off
	initial begin : receiver
		rx_mode_t mode;
		int len;
		int rx_cycles;
		bit held;
		rx_cycles = 0;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && rx_cycles >= HOLDOFF_AT) begin
				held = 1'b1;
				@(negedge clk);
				m_tready <= 1'b0;
				repeat (HOLDOFF_LEN) @(negedge clk);
				rx_cycles += HOLDOFF_LEN;
			end
			mode = rx_mode_t'($urandom_range(0, 3));
			len = $urandom_range(10, 200);
			repeat (len) begin
				@(negedge clk);
				case (mode)
					RX_FREE:    m_tready <= 1'b1;
					RX_COIN:    m_tready <= 1'($urandom_range(0, 1));
					RX_MOSTLY:  m_tready <= $urandom_range(0, 7) != 0;
					RX_CADENCE: m_tready <= (rx_cycles % 5) < 2;
				endcase
				rx_cycles++;
			end
		end
	end

	// watchdog: too long without any transaction on either side
	initial begin : watchdog
		int idle;
		idle = 0;
		@(posedge arst_n);
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle = 0;
			else
				idle++;
		end
		$display("fir_filter_saturating verification failed");
		$finish;
	end

	// stimulus and verdict
	initial begin : stimulus
		coef_style_t coef_style;
		smp_style_t smp_style;
		logic cmd;
		logic [7:0] idx;
		logic [15:0] cval;
		logic [15:0] smp;
		coef_style = COEF_FULL;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// empty store gives zero even at full scale
		send_item(firs_pkg::CMD_FILTER, 8'd0, 16'h0000, 16'h7FFF);
		// unit coefficient: rounding ties go up
		send_item(firs_pkg::CMD_LOAD, 8'd0, 16'h0001, 16'h0000);
		send_item(firs_pkg::CMD_FILTER, 8'd0, 16'h0000, 16'h4000);
		send_item(firs_pkg::CMD_FILTER, 8'd0, 16'h0000, 16'hC000);
		send_item(firs_pkg::CMD_FILTER, 8'd0, 16'h0000, 16'hBFFF);
		// loads past the last tap are dropped
		send_item(firs_pkg::CMD_LOAD, 8'd255, 16'h7FFF, 16'h0000);
		send_item(firs_pkg::CMD_LOAD, 8'(firs_pkg::TAPS), 16'h7FFF, 16'h0000);
		send_item(firs_pkg::CMD_FILTER, 8'd0, 16'h0000, 16'h0000);
		// most negative coefficients times most negative samples: positive clamp
		send_item(firs_pkg::CMD_LOAD, 8'd0, 16'h8000, 16'h0000);
		send_item(firs_pkg::CMD_LOAD, 8'd1, 16'h8000, 16'h0000);
		send_item(firs_pkg::CMD_FILTER, 8'd0, 16'h0000, 16'h8000);
		send_item(firs_pkg::CMD_FILTER, 8'd0, 16'h0000, 16'h8000);
		// opposite signs: negative clamp
		send_item(firs_pkg::CMD_LOAD, 8'd0, 16'h7FFF, 16'h0000);
		send_item(firs_pkg::CMD_LOAD, 8'd1, 16'h7FFF, 16'h0000);
		send_item(firs_pkg::CMD_FILTER, 8'd0, 16'h0000, 16'h8000);
		// last tap
		send_item(firs_pkg::CMD_LOAD, 8'(firs_pkg::TAPS - 1), 16'h8000, 16'h0000);
		send_item(firs_pkg::CMD_FILTER, 8'hFF, 16'hFFFF, 16'h7FFF);
		send_item(firs_pkg::CMD_LOAD, 8'd0, 16'h0000, 16'h0000);
		send_item(firs_pkg::CMD_LOAD, 8'd1, 16'h0000, 16'h0000);
		send_item(firs_pkg::CMD_FILTER, 8'd0, 16'h0000, 16'h7FFF);
		drain_outputs();

		// random mix of coefficient loads and samples
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 100 == 0)
				coef_style = coef_style_t'($urandom_range(0, 2));
			if (n == RANDOM_ITEMS / 2)
				drain_outputs();
			cmd = $urandom_range(0, 4) == 0 ? firs_pkg::CMD_LOAD : firs_pkg::CMD_FILTER;
			idx = $urandom_range(0, 7) == 0 ? 8'($urandom_range(firs_pkg::TAPS, 255))
				: 8'($urandom_range(0, firs_pkg::TAPS - 1));
			case (coef_style)
				COEF_FULL:    cval = 16'($urandom);
				COEF_SMALL:   cval = 16'(int'($urandom_range(0, 2047)) - 1024);
				COEF_EXTREME: cval = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
			endcase
			smp_style = smp_style_t'($urandom_range(0, 3));
			case (smp_style)
				SMP_FULL:    smp = 16'($urandom);
				SMP_EXTREME: smp = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
				SMP_SMALL:   smp = 16'(int'($urandom_range(0, 127)) - 64);
				SMP_ZERO:    smp = 16'h0000;
			endcase
			send_item(cmd, idx, cval, smp);
		end

		drain_outputs();
		repeat (SETTLE) @(posedge clk);
		if (errors == 0)
			$display("fir_filter_saturating verification clean");
		else
			$display("fir_filter_saturating verification failed");
		$finish;
	end

endmodule
